>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the servo pulse sequencer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/sps_pkg.sv
// Shared types and constants of the servo pulse sequencer.
// No dependencies; every other file of the block but assert_macros.svh refers to it by scoped names.
package sps_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    localparam int IDX_W      = 3;
    localparam int POS_W      = 8;
    localparam int TICK_W     = 16;
    localparam int LEVELS_W   = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;

    localparam logic [TICK_W-1:0] BASE_TICKS_RESET  = 16'd250;
    localparam logic [TICK_W-1:0] FRAME_TICKS_RESET = 16'd3000;
    localparam logic [POS_W-1:0]  MID_POSITION      = 8'd125;

    typedef enum logic {
        OP_EVENT        = 1'b0,
        OP_SET_POSITION = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASE_TICKS  = 1'b0,
        REG_FRAME_TICKS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t              operation;
        logic [IDX_W-1:0] servo_index;
        logic [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic [LEVELS_W-1:0] channel_levels;
        logic [TICK_W-1:0]   next_interval;
        logic                frame_end;
    } result_t;

endpackage

>>> rtl/sps_in_reg.sv
// Input register of the servo pulse sequencer: holds one accepted request.
// Depends on sps_pkg for the request type.
module sps_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          advance,
    input  sps_pkg::item_t item_in,
    output logic          valid,
    output sps_pkg::item_t item_out
);

    logic           valid_reg;
    logic           valid_next;
    sps_pkg::item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

>>> rtl/sps_slot_engine.sv
// Slot state, stored positions and settings of the servo pulse sequencer, and the
// logic that turns one request into the next interval. Depends on sps_pkg.
module sps_slot_engine
#(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sps_pkg::TICK_W-1:0]       cfg_wdata,
    input  logic                             item_valid,
    input  sps_pkg::item_t                   item,
    input  logic                             out_free,
    output logic                             advance,
    output logic                             result_valid,
    output sps_pkg::result_t                 result
);

    localparam int SLOT_W  = $clog2(CHANNELS + 1);
    localparam int PIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LWIDE_W = (CHANNELS > sps_pkg::LEVELS_W) ? CHANNELS : sps_pkg::LEVELS_W;

    logic [sps_pkg::TICK_W-1:0] base_ticks_reg;
    logic [sps_pkg::TICK_W-1:0] frame_ticks_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [SLOT_W-1:0]          slot_next;
    logic [sps_pkg::TICK_W-1:0] pause_left_reg;
    logic [sps_pkg::TICK_W-1:0] pause_left_next;
    logic [CHANNELS-1:0]        levels_reg;
    logic [CHANNELS-1:0]        levels_next;
    logic [sps_pkg::POS_W-1:0]  positions_reg [CHANNELS];

    logic                       is_set;
    logic                       do_event;
    logic                       do_set;
    logic                       last_servo;
    logic [sps_pkg::POS_W-1:0]  cur_pos;
    logic [sps_pkg::TICK_W:0]   pulse_sum;
    logic [sps_pkg::TICK_W-1:0] pulse_ticks;
    logic [sps_pkg::TICK_W-1:0] pause_sub;
    logic [CHANNELS-1:0]        clear_mask;
    logic [LWIDE_W-1:0]         levels_wide;

    assign is_set   = (item.operation == sps_pkg::OP_SET_POSITION);
    assign advance  = item_valid && (is_set || out_free);
    assign do_event = advance && !is_set;
    assign do_set   = advance && is_set && (32'(item.servo_index) < CHANNELS);

    // Slot CHANNELS, after the last servo, is the pause; the event in it closes the frame.
    assign last_servo = (slot_reg == SLOT_W'(CHANNELS));
    assign cur_pos    = positions_reg[PIDX_W'(slot_reg)];
    assign pulse_sum  = {1'b0, base_ticks_reg} + (sps_pkg::TICK_W + 1)'(cur_pos);
    assign pulse_ticks = pulse_sum[sps_pkg::TICK_W] ? '1 : pulse_sum[sps_pkg::TICK_W-1:0];
    assign pause_sub  = (pause_left_reg > sps_pkg::TICK_W'(cur_pos))
                      ? pause_left_reg - sps_pkg::TICK_W'(cur_pos) : '0;

    always_comb
    begin
        clear_mask = '0;
        if (slot_reg != '0)
        begin
            clear_mask = CHANNELS'(1) << (slot_reg - SLOT_W'(1));
        end
    end

    always_comb
    begin
        slot_next       = slot_reg;
        pause_left_next = pause_left_reg;
        levels_next     = levels_reg;
        result.next_interval = pulse_ticks;
        result.frame_end     = 1'b0;
        if (last_servo)
        begin
            slot_next            = '0;
            pause_left_next      = frame_ticks_reg;
            levels_next          = '0;
            result.next_interval = pause_left_reg;
            result.frame_end     = 1'b1;
        end
        else
        begin
            slot_next       = slot_reg + SLOT_W'(1);
            pause_left_next = pause_sub;
            levels_next     = (levels_reg & ~clear_mask) | (CHANNELS'(1) << slot_reg);
        end
        levels_wide           = LWIDE_W'(levels_next);
        result.channel_levels = levels_wide[sps_pkg::LEVELS_W-1:0];
    end

    assign result_valid = do_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ticks_reg  <= sps_pkg::BASE_TICKS_RESET;
            frame_ticks_reg <= sps_pkg::FRAME_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sps_pkg::cfg_reg_t'(cfg_addr))
                sps_pkg::REG_BASE_TICKS:  base_ticks_reg  <= cfg_wdata;
                sps_pkg::REG_FRAME_TICKS: frame_ticks_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            pause_left_reg <= sps_pkg::FRAME_TICKS_RESET;
            levels_reg     <= '0;
        end
        else if (do_event)
        begin
            slot_reg       <= slot_next;
            pause_left_reg <= pause_left_next;
            levels_reg     <= levels_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                positions_reg[k] <= sps_pkg::MID_POSITION;
            end
        end
        else if (do_set)
        begin
            positions_reg[PIDX_W'(item.servo_index)] <= item.position;
        end
    end

endmodule

>>> rtl/sps_out_reg.sv
// Result register of the servo pulse sequencer, the master side of the stream.
// Depends on sps_pkg for the result type.
module sps_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sps_pkg::result_t result_in,
    input  logic             taken,
    output logic             free,
    output logic             valid,
    output sps_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    sps_pkg::result_t result_reg;

    // The register can take a new result when it is empty or being emptied now.
    assign free = !valid_reg || taken;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

>>> rtl/servo_pulse_sequencer.sv
// Top level of the servo pulse sequencer: input register, slot engine, result register.
// Depends on sps_pkg, sps_in_reg, sps_slot_engine and sps_out_reg.

// The sequencer takes one request per clock cycle, either a compare event or a position
// update, unless a compare event waits in the input register for a full result register.
// A compare event passes from the input register through the slot engine into the result
// register; position updates yield nothing and never wait for the result side. The slot
// engine is combinational on its result path: the slot, pause and level registers are
// updated in the cycle the request leaves the input register. The result register lets
// a new request be taken while an earlier result still waits. A frame is CHANNELS pulse
// events followed by one pause event flagged with tlast. The user must write the settings
// only while no request is in flight; the block itself does not enforce it.
module servo_pulse_sequencer
#(
    parameter int CHANNELS = sps_pkg::CHANNELS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sps_pkg::TICK_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sps_pkg::S_TDATA_W-1:0]   s_tdata,   // servo_index[2:0], position[10:3]
    input  logic                            s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sps_pkg::M_TDATA_W-1:0]   m_tdata,   // channel_levels[7:0], next_interval[23:8]
    output logic                            m_tlast
);

    sps_pkg::item_t   in_item;
    sps_pkg::item_t   held_item;
    sps_pkg::result_t eng_result;
    sps_pkg::result_t out_result;
    logic             held_valid;
    logic             advance;
    logic             result_valid;
    logic             out_free;

    assign in_item.operation   = sps_pkg::op_t'(s_tuser);
    assign in_item.servo_index = s_tdata[sps_pkg::IDX_W-1:0];
    assign in_item.position    = s_tdata[sps_pkg::IDX_W +: sps_pkg::POS_W];

    assign s_tready = !held_valid || advance;

    sps_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s_tvalid && s_tready),
        .advance  (advance),
        .item_in  (in_item),
        .valid    (held_valid),
        .item_out (held_item)
    );

    sps_slot_engine
    #(
        .CHANNELS (CHANNELS)
    )
    u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (held_valid),
        .item         (held_item),
        .out_free     (out_free),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (eng_result)
    );

    sps_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (result_valid),
        .result_in  (eng_result),
        .taken      (m_tready),
        .free       (out_free),
        .valid      (m_tvalid),
        .result_out (out_result)
    );

    assign m_tdata = {out_result.next_interval, out_result.channel_levels};
    assign m_tlast = out_result.frame_end;

endmodule

>>> rtl/sps_checker.sv
// Port-level checker of the servo pulse sequencer and its bind to the top level.
// Depends on sps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sps_port_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sps_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    // A result that waits must not change under the consumer.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // The closing pause of a frame has every servo output low.
    `ASSERT_IMPLIES(a_pause_low, m_tvalid && m_tlast, m_tdata[sps_pkg::LEVELS_W-1:0] == '0)

    // During a pulse at most one servo output is high.
    `ASSERT_IMPLIES(a_one_pulse, m_tvalid && !m_tlast, $onehot0(m_tdata[sps_pkg::LEVELS_W-1:0]))

    // With the result side free the input side is never blocked.
    `ASSERT_IMPLIES(a_no_block, !m_tvalid && s_tvalid, s_tready)

endmodule

bind servo_pulse_sequencer sps_port_checker u_sps_checker (.*);
